// ----- hw/rtl/parallel_camera_frame_capture_macros.svh -----
// ----------------------------------------------------------------------------
// Parallel camera frame capture: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PARALLEL_CAMERA_FRAME_CAPTURE_MACROS_SVH
`define PARALLEL_CAMERA_FRAME_CAPTURE_MACROS_SVH

// The condition implies the expression in the same cycle.
`define PCFC_ASSERT_NOW(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// The condition implies the expression in the following cycle.
`define PCFC_ASSERT_NEXT(label, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

// ----- hw/rtl/pcfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Parallel camera frame capture package
// Frame geometry constants, capture phases and the item and write types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pcfc_pkg;

  // Frame geometry.
  localparam int ROWS_PER_FRAME = 480;
  localparam int PIXELS_PER_ROW = 320;
  localparam int COLUMN_STRIDE  = 240;

  // Derived widths.
  localparam int ROW_W  = $clog2(ROWS_PER_FRAME);
  localparam int COL_W  = $clog2(PIXELS_PER_ROW + 1);
  localparam int ADDR_W = 17;
  localparam int BYTE_W = 8;
  localparam int WORD_W = 2 * BYTE_W;

  // Capture sequencer phases.
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_VS_HIGH,
    PH_VS_LOW,
    PH_HS_HIGH,
    PH_PIXELS,
    PH_HS_LOW
  } phase_t;

  // One sample of the camera pins.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              pclk_level;
    logic              hsync_level;
    logic              vsync_level;
    logic              start_capture;
  } pin_item_t;

  // One frame memory write.
  typedef struct packed {
    logic              frame_last;
    logic [WORD_W-1:0] pixel_word;
    logic [ADDR_W-1:0] write_address;
  } pixel_write_t;

endpackage

// ----- hw/rtl/parallel_camera_frame_capture.sv -----
// ----------------------------------------------------------------------------
// Parallel camera frame capture
// Samples camera sync, pixel clock and data pins and writes a rotated frame.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one sample of the camera pins per transaction.
//   After a start request the block waits for a vsync pulse, then for each
//   row waits for hsync high, pairs bytes on rising pixel clock levels into
//   16-bit pixels and waits for hsync low. Each completed pixel leaves on
//   the master stream as one frame memory write; tlast marks the final
//   write of the frame.
//   Throughput: one sample transaction per clock cycle while the master
//   stream is not stalled. Each sample passes through an input register,
//   the combinational sequencer logic and a result register before its
//   write appears on the master stream.
//   Reset returns the sequencer to idle and empties both registers.
//   When the receiver stalls, the pending write holds in the result
//   register; one more sample is then taken into the input register and
//   tready drops until the write is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module parallel_camera_frame_capture
  import pcfc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Pin samples.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [0] start_capture, [1] vsync_level, [2] hsync_level, [3] pclk_level,
  // [11:4] data_byte, [15:12] zero
  input  logic [15:0] s_axis_tdata,
  // Frame memory writes.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [16:0] write_address, [32:17] pixel_word, [39:33] zero
  output logic [39:0] m_axis_tdata,
  // frame_last
  output logic        m_axis_tlast
);

  logic         in_valid;
  pin_item_t    in_item;
  logic         advance;
  logic         wr_valid;
  pixel_write_t wr;
  logic         out_valid;
  pixel_write_t out_wr;

  // A held sample moves on when the result register is free or draining.
  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item.start_capture <= s_axis_tdata[0];
      in_item.vsync_level   <= s_axis_tdata[1];
      in_item.hsync_level   <= s_axis_tdata[2];
      in_item.pclk_level    <= s_axis_tdata[3];
      in_item.data_byte     <= s_axis_tdata[11:4];
    end
  end

  pcfc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item       (in_item),
    .wr_valid   (wr_valid),
    .wr         (wr)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= wr_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && wr_valid) begin
      out_wr <= wr;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_wr.pixel_word, out_wr.write_address};
  assign m_axis_tlast  = out_wr.frame_last;

endmodule

// ----- hw/rtl/pcfc_core.sv -----
// ----------------------------------------------------------------------------
// Parallel camera frame capture sequencer
// Tracks sync and pixel clock levels and forms one write per completed pixel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "parallel_camera_frame_capture_macros.svh"

module pcfc_core
  import pcfc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  pin_item_t    item,
  output logic         wr_valid,
  output pixel_write_t wr
);

  phase_t             phase, phase_next;
  logic [ROW_W-1:0]   row_count, row_count_next;
  logic [COL_W-1:0]   column_count, column_count_next;
  logic               second_byte_pending, second_byte_pending_next;
  logic               clock_low_wait, clock_low_wait_next;
  logic [BYTE_W-1:0]  first_byte_hold, first_byte_hold_next;

  logic               last_row;
  logic               row_done;
  logic               byte_strobe;
  logic [ADDR_W-1:0]  column_base;

  assign last_row    = (row_count == ROW_W'(ROWS_PER_FRAME - 1));
  assign row_done    = (column_count >= COL_W'(PIXELS_PER_ROW));
  // A byte is taken on the first high sample of the pixel clock.
  assign byte_strobe = !clock_low_wait && item.pclk_level;
  assign column_base = ADDR_W'(COLUMN_STRIDE) * ADDR_W'(column_count);

  // Next phase.
  always_comb begin
    phase_next = phase;
    case (phase)
      PH_IDLE:    if (item.start_capture) phase_next = PH_VS_HIGH;
      PH_VS_HIGH: if (item.vsync_level) phase_next = PH_VS_LOW;
      PH_VS_LOW:  if (!item.vsync_level) phase_next = PH_HS_HIGH;
      PH_HS_HIGH: if (item.hsync_level) phase_next = PH_PIXELS;
      PH_PIXELS: begin
        if (clock_low_wait && !item.pclk_level && row_done) phase_next = PH_HS_LOW;
      end
      PH_HS_LOW: begin
        if (!item.hsync_level) phase_next = last_row ? PH_IDLE : PH_HS_HIGH;
      end
      default:    phase_next = PH_IDLE;
    endcase
  end

  // Counters, byte pairing and the write itself.
  always_comb begin
    row_count_next           = row_count;
    column_count_next        = column_count;
    second_byte_pending_next = second_byte_pending;
    clock_low_wait_next      = clock_low_wait;
    first_byte_hold_next     = first_byte_hold;
    wr_valid                 = 1'b0;
    wr.write_address         = ADDR_W'(row_count >> 1) + column_base;
    wr.pixel_word            = {item.data_byte, first_byte_hold};
    wr.frame_last            = last_row &&
                               (column_count == COL_W'(PIXELS_PER_ROW - 1));
    case (phase)
      PH_IDLE: begin
        if (item.start_capture) begin
          row_count_next           = '0;
          column_count_next        = '0;
          second_byte_pending_next = 1'b0;
          clock_low_wait_next      = 1'b0;
        end
      end
      PH_VS_LOW: begin
        if (!item.vsync_level) row_count_next = '0;
      end
      PH_HS_HIGH: begin
        if (item.hsync_level) begin
          column_count_next        = '0;
          second_byte_pending_next = 1'b0;
          clock_low_wait_next      = 1'b0;
        end
      end
      PH_PIXELS: begin
        if (clock_low_wait) begin
          if (!item.pclk_level) clock_low_wait_next = 1'b0;
        end else if (byte_strobe) begin
          clock_low_wait_next = 1'b1;
          if (!second_byte_pending) begin
            first_byte_hold_next     = item.data_byte;
            second_byte_pending_next = 1'b1;
          end else begin
            wr_valid                 = item_valid;
            second_byte_pending_next = 1'b0;
            column_count_next        = column_count + 1'b1;
          end
        end
      end
      PH_HS_LOW: begin
        if (!item.hsync_level) begin
          column_count_next = '0;
          row_count_next    = last_row ? '0 : row_count + 1'b1;
        end
      end
      default: begin
        row_count_next = row_count;
      end
    endcase
  end

  // State advances only when an item is consumed.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= PH_IDLE;
      row_count           <= '0;
      column_count        <= '0;
      second_byte_pending <= 1'b0;
      clock_low_wait      <= 1'b0;
      first_byte_hold     <= '0;
    end else if (item_valid) begin
      phase               <= phase_next;
      row_count           <= row_count_next;
      column_count        <= column_count_next;
      second_byte_pending <= second_byte_pending_next;
      clock_low_wait      <= clock_low_wait_next;
      first_byte_hold     <= first_byte_hold_next;
    end
  end

  `PCFC_ASSERT_NOW(a_column_bound, 1'b1, column_count <= COL_W'(PIXELS_PER_ROW),
    "column count ran past the row length")
  `PCFC_ASSERT_NOW(a_write_in_pixels, wr_valid, phase == PH_PIXELS && second_byte_pending,
    "pixel write outside the pixel phase")
  `PCFC_ASSERT_NEXT(a_wait_after_write, wr_valid, clock_low_wait && !second_byte_pending,
    "pixel write did not arm the clock low wait")
  `PCFC_ASSERT_NEXT(a_frame_end, wr_valid && wr.frame_last, row_done && last_row,
    "last write of frame not at the final row end")

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// Parallel camera frame capture testbench
// Drives camera pin samples through the slave stream and checks every frame
// memory write against an in-bench model of the capture sequencer. Covers a
// directed start-up sequence, the rest of the first row with random pixel
// data and part of the second row under heavy idling, back-pressure and a
// sender pause.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import pcfc_pkg::*;

  localparam int STUCK_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;

  // Stimulus pacing, changed per test.
  int sample_gap_pct;
  int write_stall_pct;
  int write_hold_cycles;
  int write_stall_left;

  // Model state of the capture sequencer.
  phase_t           cap_phase;
  logic [ROW_W-1:0] row_idx;
  logic [COL_W-1:0] col_idx;
  bit               byte_pending;
  bit               await_low;
  logic [7:0]       low_byte;

  pixel_write_t expected_writes[$];
  pixel_write_t next_write;
  pixel_write_t want_write;

  int samples_sent;
  int writes_checked;
  int frames_done;
  int mismatches;
  int stuck_cycles;

  parallel_camera_frame_capture u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 10 ns clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit chance(int pct);
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic bit rnd_bit();
    return bit'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom);
  endfunction

  // Mostly short idle runs, now and then a long one.
  function automatic int idle_run(int long_max);
    if ($urandom_range(0, 9) < 8) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(10, long_max);
  endfunction

  // Start requests while a capture is running must be ignored.
  function automatic bit busy_start();
    return chance(3);
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    if (mismatches < PRINT_LIMIT) begin
      $display("tb: mismatch on %s at write %0d: got 0x%0h, want 0x%0h",
               field, writes_checked, got, want);
    end
    mismatches++;
  endtask

  // Advances the sequencer model by one pin sample; returns 1 when the
  // sample completes a pixel, with the write in w.
  function automatic bit predict_write(pin_item_t s, output pixel_write_t w);
    bit emit;
    emit = 1'b0;
    w = '0;
    case (cap_phase)
      PH_IDLE: begin
        if (s.start_capture) begin
          cap_phase    = PH_VS_HIGH;
          row_idx      = '0;
          col_idx      = '0;
          byte_pending = 1'b0;
          await_low    = 1'b0;
        end
      end
      PH_VS_HIGH: begin
        if (s.vsync_level) cap_phase = PH_VS_LOW;
      end
      PH_VS_LOW: begin
        if (!s.vsync_level) begin
          cap_phase = PH_HS_HIGH;
          row_idx   = '0;
        end
      end
      PH_HS_HIGH: begin
        if (s.hsync_level) begin
          cap_phase    = PH_PIXELS;
          col_idx      = '0;
          byte_pending = 1'b0;
          await_low    = 1'b0;
        end
      end
      PH_PIXELS: begin
        if (await_low) begin
          if (!s.pclk_level) begin
            await_low = 1'b0;
            if (col_idx >= PIXELS_PER_ROW) cap_phase = PH_HS_LOW;
          end
        end else if (s.pclk_level) begin
          await_low = 1'b1;
          if (!byte_pending) begin
            low_byte     = s.data_byte;
            byte_pending = 1'b1;
          end else begin
            // Rotated layout: odd rows land on the even row before them.
            w.write_address = ADDR_W'(row_idx >> 1) + ADDR_W'(COLUMN_STRIDE * col_idx);
            w.pixel_word    = {s.data_byte, low_byte};
            w.frame_last    = (row_idx == ROWS_PER_FRAME - 1) &&
                              (col_idx == PIXELS_PER_ROW - 1);
            emit         = 1'b1;
            byte_pending = 1'b0;
            col_idx      = col_idx + 1'b1;
          end
        end
      end
      PH_HS_LOW: begin
        if (!s.hsync_level) begin
          row_idx = row_idx + 1'b1;
          col_idx = '0;
          if (row_idx >= ROWS_PER_FRAME) begin
            cap_phase = PH_IDLE;
            row_idx   = '0;
            frames_done++;
          end else begin
            cap_phase = PH_HS_HIGH;
          end
        end
      end
      default: cap_phase = PH_IDLE;
    endcase
    return emit;
  endfunction

  // Predict on every accepted sample transaction.
  always @(posedge clk) begin
    if (rst) begin
      cap_phase    = PH_IDLE;
      row_idx      = '0;
      col_idx      = '0;
      byte_pending = 1'b0;
      await_low    = 1'b0;
      low_byte     = '0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      if (predict_write(pin_item_t'(s_axis_tdata[$bits(pin_item_t)-1:0]), next_write)) begin
        expected_writes.push_back(next_write);
      end
    end
  end

  // Compare each accepted write transaction with the oldest expected write.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_writes.size() == 0) begin
        report_mismatch("unexpected write", m_axis_tdata[ADDR_W-1:0], 0);
      end else begin
        want_write = expected_writes.pop_front();
        if (m_axis_tdata[ADDR_W-1:0] !== want_write.write_address) begin
          report_mismatch("write_address", m_axis_tdata[ADDR_W-1:0],
                          want_write.write_address);
        end
        if (m_axis_tdata[ADDR_W+WORD_W-1:ADDR_W] !== want_write.pixel_word) begin
          report_mismatch("pixel_word", m_axis_tdata[ADDR_W+WORD_W-1:ADDR_W],
                          want_write.pixel_word);
        end
        if (m_axis_tlast !== want_write.frame_last) begin
          report_mismatch("frame_last", m_axis_tlast, want_write.frame_last);
        end
        writes_checked++;
      end
    end
  end

  // Write receiver: random stalls, plus a long hold-off when a test asks.
  always @(negedge clk) begin
    if (write_hold_cycles > 0) begin
      m_axis_tready <= 1'b0;
      write_hold_cycles--;
    end else if (write_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      write_stall_left--;
    end else if (chance(write_stall_pct)) begin
      m_axis_tready <= 1'b0;
      write_stall_left = idle_run(60) - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Give up when no transaction happens on either side for too long.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb: no transaction for %0d cycles, %0d writes outstanding",
               stuck_cycles, expected_writes.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Offers one sample and returns at the falling edge after it is accepted,
  // possibly after an idle gap. Called at a falling edge.
  task automatic send_sample(pin_item_t s);
    int gap;
    s_axis_tdata  <= {4'b0000, s};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    samples_sent++;
    @(negedge clk);
    if (chance(sample_gap_pct)) begin
      gap = idle_run(40);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_pin(bit start, bit vs, bit hs, bit pclk, logic [7:0] data);
    pin_item_t s;
    s.start_capture = start;
    s.vsync_level   = vs;
    s.hsync_level   = hs;
    s.pclk_level    = pclk;
    s.data_byte     = data;
    send_sample(s);
  endtask

  task automatic sender_quiet();
    s_axis_tvalid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    while (expected_writes.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // One byte: clock high with the data, sometimes held high, then low.
  // Sync pins are ignored while the clock is high; hsync stays high on the
  // low samples, which may already fall in the end-of-row wait.
  task automatic camera_byte(logic [7:0] data, int noise);
    int extra;
    send_pin(busy_start(), rnd_bit(), rnd_bit(), 1'b1, data);
    extra = chance(noise) ? $urandom_range(1, 3) : 0;
    repeat (extra) send_pin(busy_start(), rnd_bit(), rnd_bit(), 1'b1, rnd_byte());
    extra = chance(noise) ? $urandom_range(1, 3) : 0;
    repeat (extra + 1) send_pin(busy_start(), rnd_bit(), 1'b1, 1'b0, rnd_byte());
  endtask

  // Line start: stray low hsync levels, then hsync high.
  task automatic camera_line_start(int noise);
    int n;
    n = chance(noise) ? $urandom_range(1, 4) : 0;
    repeat (n) send_pin(busy_start(), rnd_bit(), 1'b0, rnd_bit(), rnd_byte());
    send_pin(busy_start(), rnd_bit(), 1'b1, rnd_bit(), rnd_byte());
  endtask

  // A run of pixels with random data.
  task automatic camera_pixels(int count, int noise);
    for (int p = 0; p < count; p++) begin
      camera_byte(rnd_byte(), noise);
      camera_byte(rnd_byte(), noise);
    end
  endtask

  // One row from first_pixel on; the line start is skipped when the row is
  // already open.
  task automatic camera_row(int first_pixel, int noise);
    int n;
    if (first_pixel == 0) begin
      camera_line_start(noise);
    end
    camera_pixels(PIXELS_PER_ROW - first_pixel, noise);
    n = chance(noise) ? $urandom_range(1, 4) : 0;
    repeat (n) send_pin(busy_start(), rnd_bit(), 1'b1, rnd_bit(), rnd_byte());
    send_pin(busy_start(), rnd_bit(), 1'b0, rnd_bit(), rnd_byte());
  endtask

  // Two bytes of one pixel; the sync level also drives start on the
  // clock-high samples to show those pins are not looked at.
  task automatic directed_pixel(logic [7:0] lo, logic [7:0] hi, bit sync_level);
    send_pin(sync_level, sync_level, sync_level, 1'b1, lo);
    send_pin(1'b0, 1'b0, 1'b1, 1'b0, ~lo);
    send_pin(sync_level, sync_level, sync_level, 1'b1, hi);
    send_pin(1'b0, 1'b0, 1'b1, 1'b0, ~hi);
  endtask

  // Samples without a start request leave an idle block idle.
  task automatic test_idle_samples_ignored();
    repeat (10) send_pin(1'b0, rnd_bit(), rnd_bit(), rnd_bit(), rnd_byte());
    send_pin(1'b0, 1'b1, 1'b1, 1'b1, 8'hFF);
    send_pin(1'b0, 1'b0, 1'b0, 1'b0, 8'h00);
  endtask

  // Start-up sequence and the first pixels of row 0 with extreme bytes.
  task automatic test_directed_first_pixels();
    // Arming sample: only its start pin is examined.
    send_pin(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    // Busy start ignored while vsync is still low.
    send_pin(1'b1, 1'b0, 1'b1, 1'b1, 8'h00);
    send_pin(1'b0, 1'b1, 1'b0, 1'b0, 8'h00);
    send_pin(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF);
    // Vsync falls; hsync high on the same sample is not taken as line start.
    send_pin(1'b0, 1'b0, 1'b1, 1'b1, 8'hAA);
    send_pin(1'b0, 1'b0, 1'b0, 1'b1, 8'h55);
    // Line start with the clock high: that level does not take a byte.
    send_pin(1'b0, 1'b0, 1'b1, 1'b1, 8'h55);
    // Pixel 0 with the clock held high over two samples.
    send_pin(1'b0, 1'b0, 1'b1, 1'b1, 8'h00);
    send_pin(1'b0, 1'b0, 1'b1, 1'b1, 8'hC3);
    send_pin(1'b0, 1'b0, 1'b1, 1'b0, 8'hFF);
    send_pin(1'b0, 1'b0, 1'b1, 1'b1, 8'hFF);
    send_pin(1'b0, 1'b0, 1'b1, 1'b0, 8'h00);
    directed_pixel(8'hFF, 8'h00, 1'b1);
    directed_pixel(8'h00, 8'h00, 1'b0);
    directed_pixel(8'hFF, 8'hFF, 1'b1);
  endtask

  // Rest of row 0 with random pixel data and light idling, closed by the
  // clock-low and hsync-low waits.
  task automatic test_finish_first_row();
    sample_gap_pct  = 1;
    write_stall_pct = 1;
    camera_row(4, 3);
  endtask

  // Part of row 1 under heavy idling, stray levels, a long receiver
  // hold-off and a sender pause until all writes are out.
  task automatic test_backpressure_row();
    sample_gap_pct  = 25;
    write_stall_pct = 25;
    camera_line_start(30);
    write_hold_cycles = 300;
    camera_pixels(20, 30);
    sender_quiet();
    wait_for_drain();
    camera_pixels(20, 30);
  endtask

  initial begin
    rst               = 1'b1;
    s_axis_tvalid     = 1'b0;
    s_axis_tdata      = '0;
    m_axis_tready     = 1'b0;
    sample_gap_pct    = 20;
    write_stall_pct   = 20;
    write_hold_cycles = 0;
    write_stall_left  = 0;
    samples_sent      = 0;
    writes_checked    = 0;
    frames_done       = 0;
    mismatches        = 0;
    stuck_cycles      = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_idle_samples_ignored();
    test_directed_first_pixels();
    test_finish_first_row();
    test_backpressure_row();

    // Drain, then keep watching for stray writes.
    sender_quiet();
    wait_for_drain();
    repeat (10) @(posedge clk);
    if (expected_writes.size() != 0) begin
      report_mismatch("writes never delivered", 0, expected_writes.size());
    end

    $display("tb: %0d pin samples, %0d pixel writes checked, %0d frames completed",
             samples_sent, writes_checked, frames_done);
    $display("tb: sync waits, row end, held clock levels, busy starts, stalls and pauses seen");
    if (mismatches == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/pcfc_pkg.sv
hw/rtl/pcfc_core.sv
hw/rtl/parallel_camera_frame_capture.sv
tb/tb.sv
